// ===== sv/dklog_pkg.sv =====
// Shared types and codes for the date keyed measurement log.
`timescale 1ns / 1ps

package dklog_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_FIND = 2'd1,
    OP_DEL  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    date_t              date;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    opcode_e            opcode;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] found_value;
    logic [4:0]         entry_count;
  } out_word_t;

endpackage

// ===== sv/dklog_mem.sv =====
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module dklog_mem
  import dklog_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/date_keyed_measurement_log.sv =====
// Date keyed measurement log: an ordered store of dated Q16.16 values with add, find, delete.
`timescale 1ns / 1ps

// Holds up to DEPTH entries in insertion order, each a date (day, month,
// year) and a raw 32-bit signed Q16.16 value. Every command word on in_i
// yields exactly one result word on out_o: a status, the found value (zero
// unless a find hits) and the entry count after the command, modulo 32.
// Add appends when the log is empty, or when the last entry's year and
// month are each no greater than the new ones (day is not checked); a full
// log answers ST_FULL before the order check. Find and delete match on the
// full date, oldest entry first; delete closes the gap so the order of the
// rest is kept. Unused opcodes answer ST_MISS. Timing: the entries live in
// one single-port-read memory with a registered read, and every scan walks
// it one entry per cycle. A delete that hits scans up to the hit, then
// moves each later entry down one slot. A new command word is taken as
// soon as the block is back in idle, even while the previous result still
// waits on out_o; no clearing pass is needed after reset.
module date_keyed_measurement_log
  import dklog_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a command word
    S_ADDCHK,  // last entry arrives from memory, apply the order rule
    S_SCMP,    // scanning: entry idx_q arrives, compare with the key
    S_SHIFT,   // delete: entry idx_q arrives, move it down one slot
    S_RES      // result ready, wait for the output register to free up
  } state_e;

  state_e    state_q;
  logic [CW-1:0] count_q;   // entries held
  logic [CW-1:0] idx_q;     // entry whose read data is on rdata this cycle
  in_word_t  cmd_q;
  status_e   res_status_q;
  logic signed [31:0] res_found_q;
  logic      out_valid_q;
  out_word_t out_q;

  // memory port
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  logic [CW-1:0] idx_next;
  logic          idx_last;   // idx_q is the newest entry
  logic          key_hit;
  logic          order_ok;
  logic          log_full;
  logic          in_fire;
  logic          out_load;   // result moves into the output register
  logic [31:0]   count_ext;

  assign idx_next  = idx_q + CW'(1);
  assign idx_last  = (idx_next == count_q);
  assign key_hit   = (rdata.date.day == cmd_q.day) && (rdata.date.month == cmd_q.month)
                     && (rdata.date.year == cmd_q.year);
  assign order_ok  = (rdata.date.year <= cmd_q.year) && (rdata.date.month <= cmd_q.month);
  assign log_full  = (count_q == CW'(DEPTH));
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_load  = (state_q == S_RES) && (!out_valid_q || out_ready_i);
  assign count_ext = 32'(count_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // memory address and write control
  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = '{date: '{year: cmd_q.year, month: cmd_q.month, day: cmd_q.day},
              value: cmd_q.value};
    raddr = '0;
    case (state_q)
      S_IDLE: begin
        // fetch the last entry for the order check; empty log writes at once
        raddr = AW'(count_q - CW'(1));
        if (in_fire && (in_i.opcode == OP_ADD) && (count_q == '0)) begin
          we    = 1'b1;
          waddr = '0;
          wdata = '{date: '{year: in_i.year, month: in_i.month, day: in_i.day},
                    value: in_i.value};
        end else if (in_fire && (in_i.opcode != OP_ADD)) begin
          raddr = '0;
        end
      end
      S_ADDCHK: begin
        we = order_ok;
      end
      S_SCMP: begin
        raddr = idx_next[AW-1:0];
      end
      S_SHIFT: begin
        raddr = idx_next[AW-1:0];
        we    = 1'b1;
        waddr = AW'(idx_q - CW'(1));
        wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  dklog_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_MISS;
      res_found_q  <= '0;
      cmd_q        <= '0;
      out_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q       <= in_i;
            idx_q       <= '0;
            res_found_q <= '0;
            case (in_i.opcode)
              OP_ADD: begin
                if (log_full) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_RES;
                end else if (count_q == '0) begin
                  count_q      <= CW'(1);
                  res_status_q <= ST_DONE;
                  state_q      <= S_RES;
                end else begin
                  res_status_q <= ST_MISS;
                  state_q      <= S_ADDCHK;
                end
              end
              OP_FIND, OP_DEL: begin
                res_status_q <= ST_MISS;
                state_q      <= (count_q == '0) ? S_RES : S_SCMP;
              end
              default: begin
                res_status_q <= ST_MISS;
                state_q      <= S_RES;
              end
            endcase
          end
        end
        S_ADDCHK: begin
          if (order_ok) begin
            count_q      <= count_q + CW'(1);
            res_status_q <= ST_DONE;
          end
          state_q <= S_RES;
        end
        S_SCMP: begin
          if (key_hit) begin
            res_status_q <= ST_DONE;
            if (cmd_q.opcode == OP_FIND) begin
              res_found_q <= rdata.value;
              state_q     <= S_RES;
            end else if (idx_last) begin
              count_q <= count_q - CW'(1);
              state_q <= S_RES;
            end else begin
              idx_q   <= idx_next;
              state_q <= S_SHIFT;
            end
          end else if (idx_last) begin
            state_q <= S_RES;
          end else begin
            idx_q <= idx_next;
          end
        end
        S_SHIFT: begin
          if (idx_last) begin
            count_q <= count_q - CW'(1);
            state_q <= S_RES;
          end else begin
            idx_q <= idx_next;
          end
        end
        S_RES: begin
          if (out_load) begin
            out_q.status      <= res_status_q;
            out_q.found_value <= res_found_q;
            out_q.entry_count <= count_ext[4:0];
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/dklog_checker.sv =====
// Port-level checker for the date keyed measurement log, bound to the top level.
`timescale 1ns / 1ps

module dklog_port_checks
  import dklog_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_o
);

  localparam logic [4:0] DepthMod = 5'(DEPTH);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result word changed while stalled");

  // count never exceeds capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (DEPTH < 32) |-> out_o.entry_count <= DepthMod)
    else $error("entry count above capacity");

  // full is only reported with the log at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == ST_FULL) |-> out_o.entry_count == DepthMod)
    else $error("full status with log not at capacity");

  // a nonzero value only comes with a successful command
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.found_value != '0) |-> out_o.status == ST_DONE)
    else $error("found value returned on a failed command");

endmodule

bind date_keyed_measurement_log dklog_port_checks #(.DEPTH(DEPTH)) u_dklog_port_checks (.*);

// ===== bench/dklog_checker.sv =====
// Watches both channels of the measurement log, predicts every result word and compares.
`timescale 1ns / 1ps

module dklog_checker
  import dklog_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_count_o
);

  localparam int MAX_PRINTED = 40;

  // Shadow copy of the log contents, oldest entry at index 0.
  date_t              log_dates  [DEPTH];
  logic signed [31:0] log_values [DEPTH];
  int                 log_used;

  out_word_t answers_q[$];
  int        mismatches;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Applies one command word to the shadow log and returns its answer.
  function automatic out_word_t predict_answer(input in_word_t cmd);
    out_word_t ans;
    date_t     key;
    int        hit;
    int        i;
    key             = {cmd.year, cmd.month, cmd.day};
    ans.status      = ST_MISS;
    ans.found_value = '0;
    hit             = -1;
    for (i = 0; i < log_used; i++) begin
      if (hit < 0 && log_dates[i] == key) begin
        hit = i;
      end
    end
    case (cmd.opcode)
      OP_ADD: begin
        // full check wins over the order rule; day never takes part
        if (log_used >= DEPTH) begin
          ans.status = ST_FULL;
        end else if (log_used == 0 ||
                     (log_dates[log_used-1].year <= cmd.year &&
                      log_dates[log_used-1].month <= cmd.month)) begin
          log_dates[log_used]  = key;
          log_values[log_used] = cmd.value;
          log_used++;
          ans.status = ST_DONE;
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          ans.status      = ST_DONE;
          ans.found_value = log_values[hit];
        end
      end
      OP_DEL: begin
        if (hit >= 0) begin
          for (i = hit; i < log_used - 1; i++) begin
            log_dates[i]  = log_dates[i+1];
            log_values[i] = log_values[i+1];
          end
          log_used--;
          ans.status = ST_DONE;
        end
      end
      default: ;
    endcase
    ans.entry_count = 5'(log_used);
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      answers_q.delete();
      log_used        = 0;
      mismatches      = 0;
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word status=%0d value=%h count=%0d",
                                    out_word_i.status, out_word_i.found_value,
                                    out_word_i.entry_count));
        end else begin
          want = answers_q.pop_front();
          if (out_word_i.status !== want.status) begin
            report_mismatch($sformatf("status %0d, wanted %0d",
                                      out_word_i.status, want.status));
          end
          if (out_word_i.found_value !== want.found_value) begin
            report_mismatch($sformatf("found_value %h, wanted %h",
                                      out_word_i.found_value, want.found_value));
          end
          if (out_word_i.entry_count !== want.entry_count) begin
            report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                      out_word_i.entry_count, want.entry_count));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        answers_q.push_back(predict_answer(in_word_i));
      end
      fail_count_o    <= mismatches;
      pending_count_o <= answers_q.size();
    end
  end

endmodule

// ===== bench/tb_date_keyed_measurement_log.sv =====
// Top of the measurement log bench: clock, reset, command stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module tb_date_keyed_measurement_log;
  import dklog_pkg::*;

  localparam int DEPTH        = 16;
  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_WORDS = 1850;
  localparam int DRAIN_CYCLES = 60;      // a full-log delete is well under this
  localparam int HOLD_START   = 1500;    // receiver cycle at which the long hold-off begins
  localparam int LONG_HOLD    = 400;
  localparam int LIMIT_NS     = 6000000; // several times the slowest legal run

  // opcode value the block must answer with a miss
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  int        fail_count;
  int        pending_count;

  // Dates the log should hold right now, oldest first. Only used to aim
  // adds, finds and deletes at live entries; never used for checking.
  date_t held_dates[$];
  bit    filling    = 1'b1;
  int    burst_left = 8;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  date_keyed_measurement_log #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_word)
  );

  dklog_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_word_i      (in_word),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_word_i     (out_word),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  function automatic date_t mk_date(input logic [13:0] y, input logic [3:0] m,
                                    input logic [4:0] d);
    date_t r;
    r.year  = y;
    r.month = m;
    r.day   = d;
    return r;
  endfunction

  function automatic in_word_t word_of(input logic [1:0] op, input date_t d,
                                       input logic [31:0] v);
    return in_word_t'({op, d.day, d.month, d.year, v});
  endfunction

  // Any date the fields can carry, calendar-valid or not; years use all 14 bits.
  function automatic date_t any_date();
    return mk_date(14'($urandom_range(0, 16383)), 4'($urandom_range(0, 15)),
                   5'($urandom_range(0, 31)));
  endfunction

  // Q16.16 payload: mostly random patterns, sometimes the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Date for an add that should pass the order rule: creep forward from
  // the newest entry, year and month never going back.
  function automatic date_t next_add_date();
    date_t last;
    date_t d;
    if (held_dates.size() == 0) begin
      d = any_date();
      // leave headroom for the month to climb in most fresh logs
      if ($urandom_range(0, 1) == 1) d.month = 4'($urandom_range(0, 3));
      return d;
    end
    last  = held_dates[$];
    d     = last;
    d.day = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 3) == 0 && d.year != 14'h3fff) d.year = d.year + 14'd1;
    if ($urandom_range(0, 2) == 0 && d.month != 4'hf) d.month = d.month + 4'd1;
    // exact duplicates exercise first-match on find and delete
    if ($urandom_range(0, 4) == 0) d.day = last.day;
    return d;
  endfunction

  // Search key: mostly a live date, sometimes a near miss or pure noise.
  function automatic date_t key_date();
    date_t d;
    if (held_dates.size() == 0 || $urandom_range(0, 9) < 2) return any_date();
    d = held_dates[$urandom_range(0, held_dates.size() - 1)];
    if ($urandom_range(0, 9) == 0) d.day = d.day ^ 5'($urandom_range(1, 31));
    return d;
  endfunction

  // Fill phases push the log to full (and keep adding into it for a
  // while); drain phases empty it again, mostly through hitting deletes.
  function automatic in_word_t random_word();
    int r;
    if (held_dates.size() == 0) filling = 1'b1;
    else if (held_dates.size() == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
    else if ($urandom_range(0, 199) == 0) filling = ~filling;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 60)      return word_of(OP_ADD, next_add_date(), pick_value());
      else if (r < 65) return word_of(OP_ADD, any_date(), pick_value());
      else if (r < 83) return word_of(OP_FIND, key_date(), pick_value());
      else if (r < 97) return word_of(OP_DEL, key_date(), pick_value());
      else             return word_of(OP_UNUSED, any_date(), pick_value());
    end else begin
      if (r < 15)      return word_of(OP_ADD, next_add_date(), pick_value());
      else if (r < 22) return word_of(OP_ADD, any_date(), pick_value());
      else if (r < 40) return word_of(OP_FIND, key_date(), pick_value());
      else if (r < 97) return word_of(OP_DEL, key_date(), pick_value());
      else             return word_of(OP_UNUSED, any_date(), pick_value());
    end
  endfunction

  // Keep held_dates in step with an accepted word.
  function automatic void note_word(input in_word_t w);
    date_t d;
    bit    gone;
    int    i;
    d    = mk_date(w.year, w.month, w.day);
    gone = 1'b0;
    case (w.opcode)
      OP_ADD: begin
        if (held_dates.size() < DEPTH &&
            (held_dates.size() == 0 ||
             (held_dates[$].year <= d.year && held_dates[$].month <= d.month))) begin
          held_dates.push_back(d);
        end
      end
      OP_DEL: begin
        for (i = 0; i < held_dates.size() && !gone; i++) begin
          if (held_dates[i] == d) begin
            held_dates.delete(i);
            gone = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one word and hold it until accepted. Words go out in bursts;
  // when a burst runs out, valid drops for a random gap. Sampling just
  // after the edge sees the pre-edge values, i.e. what the DUT saw.
  task automatic push_word(input in_word_t w);
    int gap;
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    note_word(w);
    burst_left--;
    if (burst_left <= 0) begin
      gap      = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      // now and then a long burst, so stretches run with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
  endtask

  // Result side: segments of always-ready, coin-flip and stalled cycles,
  // plus one long hold-off so the result slot fills and in_ready drops.
  initial begin : result_sink
    int  seg_len;
    int  mode;
    int  cycles_seen;
    bit  held_long;
    cycles_seen = 0;
    held_long   = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held_long && cycles_seen >= HOLD_START) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        cycles_seen += LONG_HOLD;
        held_long   = 1'b1;
      end
      mode    = $urandom_range(0, 2);
      seg_len = (mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 60);
      repeat (seg_len) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= 1'b0;
        endcase
        @(posedge clk_i);
        cycles_seen++;
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("date_keyed_measurement_log verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty log: every search misses, unused opcode misses.
    push_word(word_of(OP_FIND, mk_date(14'd0, 4'd0, 5'd0), 32'h0));
    push_word(word_of(OP_DEL, mk_date(14'd0, 4'd0, 5'd0), 32'h0));
    push_word(word_of(OP_UNUSED, mk_date(14'd0, 4'd0, 5'd0), 32'h0));
    // Lowest and highest dates, with the extreme values.
    push_word(word_of(OP_ADD, mk_date(14'd0, 4'd0, 5'd0), 32'h8000_0000));
    push_word(word_of(OP_ADD, mk_date(14'h3fff, 4'hf, 5'h1f), 32'h7fff_ffff));
    // Order rule: year going back, then month going back, both refused.
    push_word(word_of(OP_ADD, mk_date(14'd0, 4'hf, 5'h1f), 32'h1234_5678));
    push_word(word_of(OP_ADD, mk_date(14'h3fff, 4'd0, 5'h1f), 32'h1234_5678));
    // Earlier day in the same month still goes in: day is not ordered.
    push_word(word_of(OP_ADD, mk_date(14'h3fff, 4'hf, 5'd0), 32'hffff_ffff));
    push_word(word_of(OP_FIND, mk_date(14'h3fff, 4'hf, 5'h1f), 32'h0));
    push_word(word_of(OP_FIND, mk_date(14'h3fff, 4'hf, 5'd0), 32'h0));
    // Day alone differs: miss.
    push_word(word_of(OP_FIND, mk_date(14'h3fff, 4'hf, 5'd30), 32'h0));
    push_word(word_of(OP_FIND, mk_date(14'd0, 4'd0, 5'd0), 32'h0));
    // Delete from the middle, then check the tail moved down intact.
    push_word(word_of(OP_DEL, mk_date(14'h3fff, 4'hf, 5'h1f), 32'h0));
    push_word(word_of(OP_FIND, mk_date(14'h3fff, 4'hf, 5'h1f), 32'h0));
    push_word(word_of(OP_FIND, mk_date(14'h3fff, 4'hf, 5'd0), 32'h0));
    // Duplicate dates: find and delete take the oldest one.
    push_word(word_of(OP_ADD, mk_date(14'h3fff, 4'hf, 5'd5), 32'h0001_0000));
    push_word(word_of(OP_ADD, mk_date(14'h3fff, 4'hf, 5'd5), 32'hfffe_8000));
    push_word(word_of(OP_FIND, mk_date(14'h3fff, 4'hf, 5'd5), 32'h0));
    push_word(word_of(OP_DEL, mk_date(14'h3fff, 4'hf, 5'd5), 32'h0));
    push_word(word_of(OP_FIND, mk_date(14'h3fff, 4'hf, 5'd5), 32'h0));
    push_word(word_of(OP_UNUSED, mk_date(14'h3fff, 4'hf, 5'd5), 32'hdead_beef));
    // Delete the head, then a second delete of it misses.
    push_word(word_of(OP_DEL, mk_date(14'd0, 4'd0, 5'd0), 32'h0));
    push_word(word_of(OP_DEL, mk_date(14'd0, 4'd0, 5'd0), 32'h0));
    // Empty the log so the random part starts fresh.
    push_word(word_of(OP_DEL, mk_date(14'h3fff, 4'hf, 5'd0), 32'h0));
    push_word(word_of(OP_DEL, mk_date(14'h3fff, 4'hf, 5'd5), 32'h0));

    repeat (RANDOM_WORDS) push_word(random_word());
    in_valid <= 1'b0;

    // One edge first so the checker has counted the last word.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("date_keyed_measurement_log verification clean");
    end else begin
      $display("date_keyed_measurement_log verification failed");
    end
    $finish;
  end

endmodule
